// ===== rtl/frx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package frx_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 256;
    localparam logic [7:0] START_MARKER_RST = 8'hAA;

    // start, type and length come before the payload
    localparam int HDR_BYTES = 3;
    // wide enough for header plus the largest length byte
    localparam int CMP_W = 10;

    typedef enum logic [2:0] {
        ST_SKIP     = 3'd0,
        ST_HEADER   = 3'd1,
        ST_PAYLOAD  = 3'd2,
        ST_GOOD     = 3'd3,
        ST_BAD      = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
    } frx_result_t;

endpackage

`default_nettype wire

// ===== rtl/frx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface frx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface frx_status_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_type;
    logic [7:0] frame_length;

    modport source (
        output valid, output status, output payload_byte, output payload_index,
        output frame_type, output frame_length, input ready
    );
    modport sink (
        input valid, input status, input payload_byte, input payload_index,
        input frame_type, input frame_length, output ready
    );
endinterface

interface frx_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] wdata;

    modport source (output valid, output wdata, input ready);
    modport sink (input valid, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/frx_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frx_in_stage
    import frx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    frx_byte_if.sink        in_ch,
    input  wire logic       down_ready,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign in_ch.ready = !valid_reg || down_ready;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_ch.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/frx_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frx_parse
    import frx_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  byte_valid,
    input  wire logic  [7:0] byte_data,
    input  wire logic  down_ready,
    input  wire logic  [7:0] start_marker,
    output frx_result_t result
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [CNT_W:0] MAX_C = (CNT_W + 1)'(MAX_FRAME_BYTES);
    localparam logic [CMP_W-1:0] HDR_C = CMP_W'(HDR_BYTES);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic [7:0]       type_reg;
    logic [7:0]       type_next;
    logic [7:0]       len_reg;
    logic [7:0]       len_next;

    logic             fire;
    logic [CNT_W:0]   cnt_inc;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] pay_end;
    logic [CMP_W-1:0] pidx_full;

    assign fire      = byte_valid && down_ready;
    assign cnt_inc   = {1'b0, cnt_reg} + (CNT_W + 1)'(1);
    assign pos_ext   = CMP_W'(cnt_reg);
    assign pay_end   = HDR_C + CMP_W'(len_reg);
    assign pidx_full = pos_ext - HDR_C;

    always_comb
    begin
        cnt_next  = cnt_reg;
        xor_next  = xor_reg;
        type_next = type_reg;
        len_next  = len_reg;
        result    = '{status: ST_SKIP, default: '0};

        if (cnt_reg == '0 && byte_data != start_marker)
        begin
            result.status = ST_SKIP;
        end
        else if (cnt_inc >= MAX_C)
        begin
            // frame ran past the buffer, drop it
            result.status = ST_OVERFLOW;
            cnt_next      = '0;
            xor_next      = '0;
        end
        else if (pos_ext < HDR_C)
        begin
            if (pos_ext == CMP_W'(1))
            begin
                type_next = byte_data;
            end
            else if (pos_ext == CMP_W'(2))
            begin
                len_next = byte_data;
            end
            cnt_next      = cnt_inc[CNT_W-1:0];
            xor_next      = xor_reg ^ byte_data;
            result.status = ST_HEADER;
        end
        else if (pos_ext < pay_end)
        begin
            cnt_next             = cnt_inc[CNT_W-1:0];
            xor_next             = xor_reg ^ byte_data;
            result.status        = ST_PAYLOAD;
            result.payload_byte  = byte_data;
            result.payload_index = pidx_full[7:0];
        end
        else
        begin
            result.status       = (byte_data == xor_reg) ? ST_GOOD : ST_BAD;
            result.frame_type   = type_reg;
            result.frame_length = len_reg;
            cnt_next            = '0;
            xor_next            = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            xor_reg  <= '0;
            type_reg <= '0;
            len_reg  <= '0;
        end
        else if (fire)
        begin
            cnt_reg  <= cnt_next;
            xor_reg  <= xor_next;
            type_reg <= type_next;
            len_reg  <= len_next;
        end
    end

`ifndef SYNTH
    a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cnt_reg} < MAX_C)
        else $error("byte count reached frame limit");

    a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (result.status == ST_GOOD || result.status == ST_BAD ||
                 result.status == ST_OVERFLOW) |=> cnt_reg == '0 && xor_reg == '0)
        else $error("receiver did not return to hunting after frame end");

    a_skip_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.status == ST_SKIP |=> cnt_reg == '0 && $stable(xor_reg))
        else $error("skipped byte changed state");

    a_payload_counts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.status == ST_PAYLOAD |=>
        cnt_reg == $past(cnt_reg) + CNT_W'(1) && $stable(len_reg))
        else $error("payload byte did not advance count");
`endif

endmodule

`default_nettype wire

// ===== rtl/frx_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frx_out_stage
    import frx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    input  wire frx_result_t up_result,
    output logic             up_ready,
    frx_status_if.source     out_ch
);

    logic        valid_reg;
    logic        valid_next;
    frx_result_t res_reg;
    logic        load;

    assign up_ready = !valid_reg || out_ch.ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= up_result;
        end
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.status        = res_reg.status;
    assign out_ch.payload_byte  = res_reg.payload_byte;
    assign out_ch.payload_index = res_reg.payload_index;
    assign out_ch.frame_type    = res_reg.frame_type;
    assign out_ch.frame_length  = res_reg.frame_length;

endmodule

`default_nettype wire

// ===== rtl/xor_checked_frame_receiver_core.sv =====
// path: a byte's status passes through the input register, the parser and then the output register
// throughput: one byte per cycle while out_ch.ready holds; counter and running xor update in the same cycle
// an input register and an output register decouple the two channels
// reset: rst_n is asynchronous, active low; receiver hunts for start, marker is 0xaa
// configuration writes are always ready and take effect on the next byte
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_receiver_core
    import frx_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    frx_cfg_if.sink       cfg,
    frx_byte_if.sink      in_ch,
    frx_status_if.source  out_ch
);

    logic        marker_wr;
    logic [7:0]  start_marker_reg;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        down_ready;
    frx_result_t result;

    assign cfg.ready = 1'b1;
    assign marker_wr = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
        end
        else if (marker_wr)
        begin
            start_marker_reg <= cfg.wdata;
        end
    end

    frx_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .down_ready (down_ready),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    frx_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_data    (byte_data),
        .down_ready   (down_ready),
        .start_marker (start_marker_reg),
        .result       (result)
    );

    frx_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (byte_valid),
        .up_result (result),
        .up_ready  (down_ready),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
